/* rtl/fscl_pkg.sv */
package fscl_pkg;

    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int BYTE_W     = 8;
    localparam int LIMIT_W    = 10;
    localparam int TRAIL_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LIMIT_W-1:0] RST_INIT_LOW  = 10'd200;
    localparam logic [LIMIT_W-1:0] RST_INIT_HIGH = 10'd256;
    localparam logic [TRAIL_W-1:0] RST_TRAILING  = 6'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILING  = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 2'd0,
        KIND_POLL   = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_FINISH = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SHIFT      = 3'd0,
        ST_WAIT       = 3'd1,
        ST_READY      = 3'd2,
        ST_CONFIGURED = 3'd3,
        ST_LOW_TMO    = 3'd4,
        ST_HIGH_TMO   = 3'd5,
        ST_DONE_LOW   = 3'd6,
        ST_PHASE_ERR  = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_WLOW  = 3'd1,
        PH_WHIGH = 3'd2,
        PH_LOAD  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    // what the back end does with one queued job
    typedef enum logic [1:0] {
        OP_SINGLE = 2'd0,
        OP_BYTE   = 2'd1,
        OP_TRAIL  = 2'd2
    } op_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              init_level;
        logic              done_level;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic                prog_level;
        logic                clock_pulse;
        logic                data_level;
        logic [STATUS_W-1:0] status;
        logic                last;
    } out_item_t;

    typedef struct packed {
        op_t                op;
        logic               prog;
        logic               data;
        status_t            status;
        logic [BYTE_W-1:0]  data_byte;
        logic [TRAIL_W-1:0] count;
    } job_t;

endpackage

/* rtl/fscl_front.sv */
module fscl_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fscl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fscl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  fscl_pkg::in_item_t              item,
    output logic                            push,
    output fscl_pkg::job_t                  push_job,
    input  logic                            queue_full
);
    import fscl_pkg::*;

    logic [LIMIT_W-1:0] init_low_limit_reg;
    logic [LIMIT_W-1:0] init_high_limit_reg;
    logic [TRAIL_W-1:0] trailing_clocks_reg;

    phase_t             phase_reg, phase_next, phase_cur;
    logic [LIMIT_W-1:0] poll_count_reg, poll_count_next, poll_inc;
    logic               prog_out_reg, prog_out_next;
    logic               data_out_reg, data_out_next;
    logic               accept;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;
    assign push       = accept;
    assign poll_inc   = poll_count_reg + 10'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_low_limit_reg  <= RST_INIT_LOW;
            init_high_limit_reg <= RST_INIT_HIGH;
            trailing_clocks_reg <= RST_TRAILING;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INIT_LOW:  init_low_limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_INIT_HIGH: init_high_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_TRAILING:  trailing_clocks_reg <= cfg_data[TRAIL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            poll_count_reg <= '0;
            prog_out_reg   <= 1'b0;
            data_out_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            poll_count_reg <= poll_count_next;
            prog_out_reg   <= prog_out_next;
            data_out_reg   <= data_out_next;
        end
    end

    always_comb
    begin
        case (phase_reg)
            PH_WLOW, PH_WHIGH, PH_LOAD, PH_DONE: phase_cur = phase_reg;
            default:                             phase_cur = PH_IDLE;
        endcase

        phase_next      = phase_reg;
        poll_count_next = poll_count_reg;
        prog_out_next   = prog_out_reg;
        data_out_next   = data_out_reg;

        push_job.op        = OP_SINGLE;
        push_job.status    = ST_PHASE_ERR;
        push_job.data_byte = item.data_byte;
        push_job.count     = trailing_clocks_reg;

        case (kind_t'(item.kind))
            KIND_START:
            begin
                prog_out_next   = 1'b0;
                data_out_next   = 1'b0;
                poll_count_next = '0;
                phase_next      = PH_WLOW;
                push_job.status = ST_WAIT;
            end
            KIND_POLL:
            begin
                case (phase_cur)
                    PH_WLOW:
                    begin
                        if (!item.init_level)
                        begin
                            prog_out_next   = 1'b1;
                            poll_count_next = '0;
                            phase_next      = PH_WHIGH;
                            push_job.status = ST_WAIT;
                        end
                        else
                        begin
                            poll_count_next = poll_inc;
                            if (poll_inc >= init_low_limit_reg)
                            begin
                                prog_out_next   = 1'b1;
                                phase_next      = PH_IDLE;
                                push_job.status = ST_LOW_TMO;
                            end
                            else
                            begin
                                push_job.status = ST_WAIT;
                            end
                        end
                    end
                    PH_WHIGH:
                    begin
                        if (item.init_level)
                        begin
                            poll_count_next = '0;
                            phase_next      = PH_LOAD;
                            push_job.status = ST_READY;
                        end
                        else
                        begin
                            poll_count_next = poll_inc;
                            if (poll_inc >= init_high_limit_reg)
                            begin
                                phase_next      = PH_IDLE;
                                push_job.status = ST_HIGH_TMO;
                            end
                            else
                            begin
                                push_job.status = ST_WAIT;
                            end
                        end
                    end
                    PH_DONE:
                    begin
                        data_out_next   = 1'b1;
                        phase_next      = PH_IDLE;
                        push_job.status = item.done_level ? ST_CONFIGURED : ST_DONE_LOW;
                    end
                    default: ;
                endcase
            end
            KIND_DATA:
            begin
                if (phase_cur == PH_LOAD)
                begin
                    push_job.op     = OP_BYTE;
                    push_job.status = ST_SHIFT;
                    // pin keeps the last bit shifted out
                    data_out_next   = item.data_byte[0];
                end
            end
            KIND_FINISH:
            begin
                if (phase_cur == PH_LOAD)
                begin
                    phase_next      = PH_DONE;
                    push_job.status = ST_WAIT;
                    if (trailing_clocks_reg != '0)
                    begin
                        push_job.op = OP_TRAIL;
                    end
                end
            end
            default: ;
        endcase

        push_job.prog = prog_out_next;
        push_job.data = data_out_next;
    end

`ifndef SYNTH
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.kind == KIND_START) |=> (phase_reg == PH_WLOW))
        else $error("start did not arm init-low wait");
`endif

endmodule

/* rtl/fscl_queue.sv */
module fscl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fscl_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output fscl_pkg::job_t head,
    output logic           empty
);
    import fscl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count overflow");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
`endif

endmodule

/* rtl/fscl_back.sv */
module fscl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  fscl_pkg::job_t      head,
    input  logic                empty,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output fscl_pkg::out_item_t result
);
    import fscl_pkg::*;

    job_t               cur_reg;
    logic               cur_valid_reg;
    logic [TRAIL_W-1:0] rem_reg, rem_load;
    logic [BYTE_W-1:0]  shift_reg;
    out_item_t          result_reg, beat;
    logic               result_valid_reg;
    logic               out_load, emit, beat_last;

    assign out_load  = !result_valid_reg || !result_stall;
    assign emit      = cur_valid_reg && out_load;
    assign beat_last = (rem_reg == '0);
    assign pop       = !empty && (!cur_valid_reg || (emit && beat_last));

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        beat.prog_level = cur_reg.prog;
        beat.last       = beat_last;
        case (cur_reg.op)
            OP_BYTE:
            begin
                beat.clock_pulse = 1'b1;
                beat.data_level  = shift_reg[BYTE_W-1];
                beat.status      = ST_SHIFT;
            end
            OP_TRAIL:
            begin
                beat.clock_pulse = 1'b1;
                beat.data_level  = cur_reg.data;
                beat.status      = beat_last ? ST_WAIT : ST_SHIFT;
            end
            default:
            begin
                beat.clock_pulse = 1'b0;
                beat.data_level  = cur_reg.data;
                beat.status      = cur_reg.status;
            end
        endcase

        case (head.op)
            OP_BYTE:  rem_load = TRAIL_W'(BYTE_W - 1);
            OP_TRAIL: rem_load = head.count - 1'b1;
            default:  rem_load = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
            end
            else if (emit && beat_last)
            begin
                cur_valid_reg <= 1'b0;
            end

            if (emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg   <= head;
            rem_reg   <= rem_load;
            shift_reg <= head.data_byte;
        end
        else if (emit)
        begin
            rem_reg   <= rem_reg - 1'b1;
            shift_reg <= {shift_reg[BYTE_W-2:0], 1'b0};
        end

        if (emit)
        begin
            result_reg <= beat;
        end
    end

`ifndef SYNTH
    a_idle_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.clock_pulse) |-> result_reg.last)
        else $error("non-clock beat is not the final beat of its job");
    a_job_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !beat_last) |=> cur_valid_reg)
        else $error("job dropped before its final beat");
`endif

endmodule

/* rtl/fpga_serial_config_loader.sv */
// Slave-serial FPGA configuration sequencer. A start item pulls the program
// pin low; poll items (carrying sampled init/done levels) walk through the
// init-low and init-high waits, each bounded by its poll-limit register, and
// report waiting, ready or a timeout. Data items become eight clocked beats,
// MSB first; a finish item becomes trailing_clocks clocked beats (or one
// unclocked beat when that register is zero), and the next poll checks done.
// Items out of phase get one beat with the out-of-phase status and change
// nothing. Every result beat carries the program level, a clock flag, the data
// level, a status code and a last flag on the final beat of each item.
// Rate: the back end issues one result beat per cycle unless the output stalls,
// and it takes the next queued job as the last beat of the current one leaves;
// the front end classifies one item per cycle, unless the queue is full, into a
// two-entry job queue, so the input keeps taking items while earlier beats are
// still leaving. A result beat sits in an output register, and the back end
// keeps working into it whenever it is empty or being taken.
// Config: write cfg_data to register cfg_index (0 init-low limit, 1 init-high
// limit, 2 trailing clocks) while the block is idle; other indexes are ignored.
module fpga_serial_config_loader (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fscl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fscl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  fscl_pkg::in_item_t              item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output fscl_pkg::out_item_t             result
);
    import fscl_pkg::*;

    // front end -> job queue
    logic push;
    job_t push_job;
    logic queue_full;

    // job queue -> back end
    logic pop;
    job_t head;
    logic queue_empty;

    // phase tracking, pin state and config registers live in the front end
    fscl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    fscl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty)
    );

    // expands each job into its beats, one per cycle while the output is not stalled
    fscl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (queue_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import fscl_pkg::*;

    // A stretch this long with no beat on either channel means the block hung.
    // Worst honest gap: the deliberate receiver hold-off plus a few idle draws.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF        = 300;  // one long receiver stall, fills the job queue
    localparam int DRAIN_CYCLES    = 16;   // settle time before a register write / verdict
    localparam int ITEMS_PER_PHASE = 76;   // five random phases, at least 380 items in all
    localparam int RANDOM_PHASES   = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index, must be ignored

    // one line of the directed plan: either a register setting or an item
    typedef struct {
        bit                 regs;
        logic [LIMIT_W-1:0] low;
        logic [LIMIT_W-1:0] high;
        logic [TRAIL_W-1:0] trail;
        in_item_t           it;
        bit                 typed;  // want holds the single beat, read off by hand
        out_item_t          want;
    } step_row_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    in_item_t              item         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    out_item_t             result;

    // shadow of the sequencer: phase, poll counter, pin levels, registers
    phase_t             sim_phase;
    logic [LIMIT_W-1:0] sim_polls;
    logic               sim_prog;
    logic               sim_data;
    logic [LIMIT_W-1:0] lim_low;
    logic [LIMIT_W-1:0] lim_high;
    logic [TRAIL_W-1:0] lim_trail;

    out_item_t beats_due[$];  // result beats still owed by the block, oldest first
    in_item_t  script[$];     // random items waiting to be offered
    step_row_t steps[$];      // directed plan

    int mismatches = 0;
    int planned    = 0;
    int quiet      = 0;
    int tx_calm    = 0;
    int rx_calm    = 0;
    bit choke_req  = 1'b0;

    fpga_serial_config_loader DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow sequencer
    // ------------------------------------------------------------------
    function automatic void emit(logic pulse, status_t st, logic fin);
        beats_due.push_back(out_item_t'{sim_prog, pulse, sim_data, st, fin});
    endfunction

    // Advance the shadow by one accepted item and queue the beats it owes.
    function automatic void load_step(in_item_t it);
        logic [BYTE_W-1:0] sh;
        int                n;
        case (it.kind)
            KIND_START:
            begin
                // abort from any phase: program low, data low, fresh count
                sim_prog  = 1'b0;
                sim_data  = 1'b0;
                sim_polls = '0;
                sim_phase = PH_WLOW;
                emit(1'b0, ST_WAIT, 1'b1);
            end
            KIND_POLL:
            begin
                case (sim_phase)
                    PH_WLOW:
                    begin
                        if (!it.init_level)
                        begin
                            // init fell: release program, wait for it to rise
                            sim_prog  = 1'b1;
                            sim_polls = '0;
                            sim_phase = PH_WHIGH;
                            emit(1'b0, ST_WAIT, 1'b1);
                        end
                        else
                        begin
                            sim_polls = sim_polls + 1'b1;
                            if (sim_polls >= lim_low)
                            begin
                                sim_prog  = 1'b1;
                                sim_phase = PH_IDLE;
                                emit(1'b0, ST_LOW_TMO, 1'b1);
                            end
                            else
                                emit(1'b0, ST_WAIT, 1'b1);
                        end
                    end
                    PH_WHIGH:
                    begin
                        if (it.init_level)
                        begin
                            sim_polls = '0;
                            sim_phase = PH_LOAD;
                            emit(1'b0, ST_READY, 1'b1);
                        end
                        else
                        begin
                            sim_polls = sim_polls + 1'b1;
                            if (sim_polls >= lim_high)
                            begin
                                // program stays released on this timeout
                                sim_phase = PH_IDLE;
                                emit(1'b0, ST_HIGH_TMO, 1'b1);
                            end
                            else
                                emit(1'b0, ST_WAIT, 1'b1);
                        end
                    end
                    PH_DONE:
                    begin
                        sim_data  = 1'b1;
                        sim_phase = PH_IDLE;
                        emit(1'b0, it.done_level ? ST_CONFIGURED : ST_DONE_LOW, 1'b1);
                    end
                    default:
                        emit(1'b0, ST_PHASE_ERR, 1'b1);
                endcase
            end
            default:
            begin
                if (sim_phase != PH_LOAD)
                    emit(1'b0, ST_PHASE_ERR, 1'b1);
                else if (it.kind == KIND_DATA)
                begin
                    // MSB first, one clocked beat per bit; data pin keeps the last bit
                    sh = it.data_byte;
                    for (n = 0; n < 8; n++)
                    begin
                        sim_data = sh[BYTE_W-1];
                        sh       = sh << 1;
                        emit(1'b1, ST_SHIFT, n == 7);
                    end
                end
                else
                begin
                    sim_phase = PH_DONE;
                    if (lim_trail == '0)
                        emit(1'b0, ST_WAIT, 1'b1);
                    else
                        for (n = 1; n <= int'(lim_trail); n++)
                            emit(1'b1, (n == int'(lim_trail)) ? ST_WAIT : ST_SHIFT,
                                 n == int'(lim_trail));
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Random idle draw per beat, with occasional calm stretches of none.
    function automatic int pause_len(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 5);
    endfunction

    function automatic step_row_t pin_row(kind_t k, logic il, logic dl, logic [BYTE_W-1:0] b,
                                          bit typed, logic p, logic d, status_t st);
        step_row_t r;
        r.regs          = 1'b0;
        r.low           = '0;
        r.high          = '0;
        r.trail         = '0;
        r.it.kind       = k;
        r.it.init_level = il;
        r.it.done_level = dl;
        r.it.data_byte  = b;
        r.typed         = typed;
        r.want          = out_item_t'{p, 1'b0, d, st, 1'b1};
        return r;
    endfunction

    function automatic step_row_t calc_row(kind_t k, logic il, logic dl, logic [BYTE_W-1:0] b);
        return pin_row(k, il, dl, b, 1'b0, 1'b0, 1'b0, ST_SHIFT);
    endfunction

    function automatic step_row_t regs_row(logic [LIMIT_W-1:0] low, logic [LIMIT_W-1:0] high,
                                           logic [TRAIL_W-1:0] trail);
        step_row_t r;
        r       = calc_row(KIND_START, 1'b0, 1'b0, 8'h00);
        r.regs  = 1'b1;
        r.low   = low;
        r.high  = high;
        r.trail = trail;
        return r;
    endfunction

    function automatic void queue_item(kind_t k, logic lvl);
        in_item_t it;
        it.kind       = k;
        it.init_level = lvl;
        it.done_level = 1'($urandom);
        it.data_byte  = 8'($urandom);
        script.push_back(it);
        planned++;
    endfunction

    // One configuration attempt: start, init-low wait, init-high wait, a few
    // bytes, finish and the done poll. Levels vary so timeouts and aborts show up;
    // now and then the session is just noise instead.
    function automatic void plan_session();
        int n;
        if ($urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n) script.push_back(in_item_t'(12'($urandom)));
            return;
        end
        queue_item(KIND_START, 1'($urandom));
        n = $urandom_range(0, 3);
        repeat (n) queue_item(KIND_POLL, 1'b1);
        queue_item(KIND_POLL, 1'b0);
        n = $urandom_range(0, 3);
        repeat (n) queue_item(KIND_POLL, 1'b0);
        queue_item(KIND_POLL, 1'b1);
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            // stray item mid-load: poll out of phase, start aborts, finish ends load
            if ($urandom_range(0, 15) == 0)
                queue_item(kind_t'($urandom_range(0, 3)), 1'($urandom));
            queue_item(KIND_DATA, 1'($urandom));
        end
        queue_item(KIND_FINISH, 1'($urandom));
        queue_item(KIND_POLL, 1'($urandom));
    endfunction

    // Offer one item beat and hold it until the block takes it.
    task automatic offer(in_item_t it);
        int gap;
        gap = pause_len(tx_calm);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        load_step(it);
    endtask

    // Stop offering and let every owed beat come out, then settle.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(logic [LIMIT_W-1:0] low, logic [LIMIT_W-1:0] high,
                                logic [TRAIL_W-1:0] trail);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INIT_LOW;
        cfg_data  <= low;
        @(posedge clk);
        cfg_index <= CFG_INIT_HIGH;
        cfg_data  <= high;
        @(posedge clk);
        cfg_index <= CFG_TRAILING;
        cfg_data  <= CFG_DATA_W'(trail);
        @(posedge clk);
        // unmapped index: the block must leave every register alone
        cfg_index <= CFG_SPARE;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        lim_low   = low;
        lim_high  = high;
        lim_trail = trail;
    endtask

    // ------------------------------------------------------------------
    // Result side: per-beat stall draws, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        forever
        begin
            if (choke_req)
            begin
                choke_req = 1'b0;
                hold      = HOLD_OFF;
            end
            else
                hold = pause_len(rx_calm);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    // Compare every accepted result beat with the oldest owed beat.
    always @(posedge clk)
    begin : beat_check
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (beats_due.size() == 0)
            begin
                $display("%0t ns: unexpected beat prog=%b clk=%b data=%b status=%0d last=%b",
                         $time, result.prog_level, result.clock_pulse, result.data_level,
                         result.status, result.last);
                mismatches++;
            end
            else
            begin
                want = beats_due.pop_front();
                if (result !== want)
                begin
                    $display({"%0t ns: beat mismatch, expected prog=%b clk=%b data=%b ",
                              "status=%0d last=%b, got prog=%b clk=%b data=%b status=%0d last=%b"},
                             $time, want.prog_level, want.clock_pulse, want.data_level,
                             want.status, want.last, result.prog_level, result.clock_pulse,
                             result.data_level, result.status, result.last);
                    mismatches++;
                end
            end
        end
    end

    // Hang detector: counts cycles with no beat moving on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet <= 0;
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int p;
        int s;

        // register values after reset
        lim_low   = RST_INIT_LOW;
        lim_high  = RST_INIT_HIGH;
        lim_trail = RST_TRAILING;
        sim_phase = PH_IDLE;
        sim_polls = '0;
        sim_prog  = 1'b0;
        sim_data  = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset register values first.
        // Out of phase while idle, pins at their reset levels.
        steps.push_back(pin_row(KIND_POLL,   1'b1, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, ST_PHASE_ERR));
        steps.push_back(pin_row(KIND_DATA,   1'b0, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0, ST_PHASE_ERR));
        // start, a poll still seeing init high, then init falls
        steps.push_back(pin_row(KIND_START,  1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, ST_WAIT));
        steps.push_back(pin_row(KIND_POLL,   1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, ST_WAIT));
        steps.push_back(pin_row(KIND_POLL,   1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ST_WAIT));
        // start in the init-high wait aborts and pulls program low again
        steps.push_back(pin_row(KIND_START,  1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, ST_WAIT));
        steps.push_back(pin_row(KIND_POLL,   1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ST_WAIT));
        steps.push_back(pin_row(KIND_POLL,   1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ST_READY));
        // a poll while loading is out of phase
        steps.push_back(pin_row(KIND_POLL,   1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0, ST_PHASE_ERR));
        steps.push_back(calc_row(KIND_DATA,  1'b0, 1'b0, 8'h00));
        steps.push_back(calc_row(KIND_DATA,  1'b1, 1'b1, 8'h81));
        steps.push_back(calc_row(KIND_FINISH, 1'b0, 1'b0, 8'h00));
        // waiting for the done poll: a second finish is out of phase
        steps.push_back(pin_row(KIND_FINISH, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1, ST_PHASE_ERR));
        steps.push_back(pin_row(KIND_POLL,   1'b0, 1'b1, 8'h00, 1'b1, 1'b1, 1'b1, ST_CONFIGURED));

        // Zero init-low limit, one-poll init-high limit, no trailing clocks.
        steps.push_back(regs_row(10'd0, 10'd1, 6'd0));
        steps.push_back(pin_row(KIND_START,  1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, ST_WAIT));
        steps.push_back(pin_row(KIND_POLL,   1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ST_LOW_TMO));
        steps.push_back(pin_row(KIND_POLL,   1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ST_PHASE_ERR));
        steps.push_back(pin_row(KIND_START,  1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, ST_WAIT));
        steps.push_back(pin_row(KIND_POLL,   1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ST_WAIT));
        steps.push_back(pin_row(KIND_POLL,   1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ST_HIGH_TMO));
        steps.push_back(pin_row(KIND_START,  1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, ST_WAIT));
        steps.push_back(pin_row(KIND_POLL,   1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ST_WAIT));
        steps.push_back(pin_row(KIND_POLL,   1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ST_READY));
        steps.push_back(calc_row(KIND_DATA,  1'b0, 1'b0, 8'h5A));
        // zero trailing clocks: one unclocked beat, data pin holds the byte's last bit
        steps.push_back(pin_row(KIND_FINISH, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ST_WAIT));
        steps.push_back(pin_row(KIND_POLL,   1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1, ST_DONE_LOW));

        for (s = 0; s < steps.size(); s++)
        begin
            if (steps[s].regs)
                program_regs(steps[s].low, steps[s].high, steps[s].trail);
            else
            begin
                offer(steps[s].it);
                if (steps[s].typed)
                    beats_due[$] = steps[s].want;
            end
        end

        // Random part: one register setting per phase, extremes included.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       program_regs(10'd1023, 10'd1023, 6'd63);
                1:       program_regs(10'd1, 10'd1, 6'd1);
                2:       program_regs(10'($urandom_range(1, 6)), 10'($urandom_range(1, 6)),
                                      6'($urandom));
                3:       program_regs(10'd0, 10'd0, 6'd0);
                default: program_regs(10'($urandom_range(1, 1023)),
                                      10'($urandom_range(1, 1023)), 6'($urandom));
            endcase
            // long receiver hold-off while items keep coming: job queue fills up
            if (p == 2)
                choke_req = 1'b1;
            planned = 0;
            while (planned < ITEMS_PER_PHASE || script.size() != 0)
            begin
                if (script.size() == 0)
                    plan_session();
                offer(script.pop_front());
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* fpga_serial_config_loader.f */
rtl/fscl_pkg.sv
rtl/fscl_front.sv
rtl/fscl_queue.sv
rtl/fscl_back.sv
rtl/fpga_serial_config_loader.sv
tb/tb.sv
